[src/ranrot_random_generator_assert.svh]
// ----------------------------------------------------------------------------
// ranrot_random_generator_assert.svh
// Assertion macros used by the ranrot generator module
// ----------------------------------------------------------------------------
`ifndef RANROT_RANDOM_GENERATOR_ASSERT_SVH
`define RANROT_RANDOM_GENERATOR_ASSERT_SVH

`ifndef NO_ASSERTIONS
// concurrent check, disabled while reset is asserted
`define RANROT_ASSERT(lbl_, clk_, rst_n_, prop_, msg_) \
  lbl_: assert property (@(posedge clk_) disable iff (!rst_n_) prop_) else $error(msg_);
// concurrent check that also holds during reset
`define RANROT_ASSERT_NR(lbl_, clk_, prop_, msg_) \
  lbl_: assert property (@(posedge clk_) prop_) else $error(msg_);
`else
`define RANROT_ASSERT(lbl_, clk_, rst_n_, prop_, msg_)
`define RANROT_ASSERT_NR(lbl_, clk_, prop_, msg_)
`endif

`endif

[src/ranrot_pkg.sv]
// ----------------------------------------------------------------------------
// ranrot_pkg
// Shared constants, types and helpers of the ranrot generator
// ----------------------------------------------------------------------------
package ranrot_pkg;

  // word and ring geometry
  localparam int WordW     = 32;
  localparam int RingDepth = 17;
  localparam int RingLast  = RingDepth - 1;
  localparam int PtrW      = $clog2(RingDepth);
  localparam int LagStart  = 10;

  // generator constants
  localparam logic [WordW-1:0] LcgMult = 32'd2891336453;
  localparam int RotLag   = 13;
  localparam int RotWrite = 9;

  // item opcodes
  localparam logic OpReseed = 1'b0;
  localparam logic OpDraw   = 1'b1;

  // configuration port
  localparam int ApbDataW = 32;
  localparam int ApbAddrW = 3;
  localparam logic RegFallbackSeed = 1'b0;

  // ring port request from the control logic
  typedef struct packed {
    logic             rd_en;
    logic [PtrW-1:0]  rd_addr_a;
    logic [PtrW-1:0]  rd_addr_b;
    logic             wr_en;
    logic [PtrW-1:0]  wr_addr;
    logic [WordW-1:0] wr_data;
  } ring_req_t;

  // rotate left by a constant amount
  function automatic logic [WordW-1:0] rotl(logic [WordW-1:0] v, int amt);
    return (v << amt) | (v >> (WordW - amt));
  endfunction

endpackage

[src/ranrot_in_if.sv]
// ----------------------------------------------------------------------------
// ranrot_in_if
// Command channel: reseed or draw item with valid/ready handshake
// ----------------------------------------------------------------------------
interface ranrot_in_if;
  logic                          valid;
  logic                          ready;
  logic                          opcode;
  logic [ranrot_pkg::WordW-1:0]  seed_value;

  modport source (output valid, output opcode, output seed_value, input ready);
  modport sink   (input valid, input opcode, input seed_value, output ready);
endinterface

[src/ranrot_out_if.sv]
// ----------------------------------------------------------------------------
// ranrot_out_if
// Result channel: one random word per draw item
// ----------------------------------------------------------------------------
interface ranrot_out_if;
  logic                          valid;
  logic                          ready;
  logic [ranrot_pkg::WordW-1:0]  random_word;

  modport source (output valid, output random_word, input ready);
  modport sink   (input valid, input random_word, output ready);
endinterface

[src/ranrot_ring.sv]
// ----------------------------------------------------------------------------
// ranrot_ring
// Lag ring storage: two registered read ports, one write port; entries
// that were never written read as zero
// ----------------------------------------------------------------------------
module ranrot_ring (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  ranrot_pkg::ring_req_t         req_i,
  output logic [ranrot_pkg::WordW-1:0]  rd_a_o,
  output logic [ranrot_pkg::WordW-1:0]  rd_b_o
);

  logic [ranrot_pkg::WordW-1:0]     mem_q [ranrot_pkg::RingDepth];
  logic [ranrot_pkg::RingDepth-1:0] vld_q;
  logic [ranrot_pkg::WordW-1:0]     rd_a_q;
  logic [ranrot_pkg::WordW-1:0]     rd_b_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (req_i.wr_en) begin
      mem_q[req_i.wr_addr] <= req_i.wr_data;
    end
  end

  // written marks, cleared by reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (req_i.wr_en) begin
      vld_q[req_i.wr_addr] <= 1'b1;
    end
  end

  // registered read ports, data held until the next read
  always_ff @(posedge clk_i) begin
    if (req_i.rd_en) begin
      rd_a_q <= vld_q[req_i.rd_addr_a] ? mem_q[req_i.rd_addr_a] : '0;
      rd_b_q <= vld_q[req_i.rd_addr_b] ? mem_q[req_i.rd_addr_b] : '0;
    end
  end

  assign rd_a_o = rd_a_q;
  assign rd_b_o = rd_b_q;

endmodule

[src/ranrot_random_generator.sv]
// ----------------------------------------------------------------------------
// ranrot_random_generator
// Lagged rotate-add random generator over a ring of 17 words
// ----------------------------------------------------------------------------
// Usage:
//   cmd_i carries items: opcode draw returns one word on rnd_o, opcode
//   reseed refills the ring from an LCG chain and returns nothing. A zero
//   seed takes the fallback_seed register (APB, address 0, reset 1).
// Draw and reseed sequence:
//   draw: accepted, ring read at both pointers, then in the compute state
//   rotate-add and write-back with the word loaded into the output register
//   that drives rnd_o, once that register is free. The ring's registered
//   read ports put the compute state between acceptance and the output
//   register; no new item is taken until the draw is back in idle.
//   reseed: 17 ring writes, one multiply per cycle; the next item is taken
//   once the last ring write is done and the state is back in idle.
// Reset:
//   ring reads as all zero until first reseed, pointers at 0 and 10.
// Receiver stall:
//   the output register holds the word; the next item is still accepted,
//   and a further draw waits in its compute cycle until the slot frees.
// ----------------------------------------------------------------------------
`include "ranrot_random_generator_assert.svh"

module ranrot_random_generator (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  ranrot_in_if.sink                        cmd_i,
  ranrot_out_if.source                     rnd_o,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [ranrot_pkg::ApbAddrW-1:0]  paddr,
  input  logic [ranrot_pkg::ApbDataW-1:0]  pwdata,
  output logic [ranrot_pkg::ApbDataW-1:0]  prdata,
  output logic                             pready
);

  typedef enum logic [1:0] {
    StIdle,
    StCalc,
    StSeed
  } state_e;

  state_e                           state_q;
  logic [ranrot_pkg::PtrW-1:0]      wp_q;
  logic [ranrot_pkg::PtrW-1:0]      lp_q;
  logic [ranrot_pkg::PtrW-1:0]      cnt_q;
  logic [ranrot_pkg::WordW-1:0]     seed_q;
  logic [ranrot_pkg::WordW-1:0]     fallback_q;
  logic                             out_valid_q;
  logic [ranrot_pkg::WordW-1:0]     out_word_q;

  ranrot_pkg::ring_req_t            ring_req;
  logic [ranrot_pkg::WordW-1:0]     rd_a;
  logic [ranrot_pkg::WordW-1:0]     rd_b;
  logic [ranrot_pkg::WordW-1:0]     word_d;
  logic [ranrot_pkg::WordW-1:0]     seed_d;
  logic                             cmd_acc;
  logic                             out_free;
  logic                             cfg_wr;
  logic [ranrot_pkg::PtrW:0]        wp_ext;
  logic [ranrot_pkg::PtrW:0]        lp_ext;

  // configuration register
  assign cfg_wr = psel && penable && pwrite && pready;
  assign pready = 1'b1;
  assign prdata = (paddr[ranrot_pkg::ApbAddrW-1] == ranrot_pkg::RegFallbackSeed) ?
                  fallback_q : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fallback_q <= ranrot_pkg::WordW'(1);
    end else if (cfg_wr && (paddr[ranrot_pkg::ApbAddrW-1] == ranrot_pkg::RegFallbackSeed)) begin
      fallback_q <= pwdata;
    end
  end

  // handshakes
  assign cmd_i.ready     = (state_q == StIdle);
  assign cmd_acc         = cmd_i.valid && cmd_i.ready;
  assign out_free        = !out_valid_q || rnd_o.ready;
  assign rnd_o.valid     = out_valid_q;
  assign rnd_o.random_word = out_word_q;

  // rotate-add of the two ring words and next LCG value
  assign word_d = ranrot_pkg::rotl(rd_b, ranrot_pkg::RotLag)
                + ranrot_pkg::rotl(rd_a, ranrot_pkg::RotWrite);
  assign seed_d = seed_q * ranrot_pkg::LcgMult + ranrot_pkg::WordW'(1);

  // ring access per state
  always_comb begin
    ring_req           = '0;
    ring_req.rd_addr_a = wp_q;
    ring_req.rd_addr_b = lp_q;
    ring_req.wr_addr   = wp_q;
    ring_req.wr_data   = word_d;
    case (state_q)
      StIdle: begin
        ring_req.rd_en = cmd_acc && (cmd_i.opcode == ranrot_pkg::OpDraw);
      end
      StCalc: begin
        ring_req.wr_en = out_free;
      end
      StSeed: begin
        ring_req.wr_en   = 1'b1;
        ring_req.wr_addr = cnt_q;
        ring_req.wr_data = seed_d;
      end
      default: begin
        ring_req.rd_en = 1'b0;
      end
    endcase
  end

  ranrot_ring u_ring (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (ring_req),
    .rd_a_o (rd_a),
    .rd_b_o (rd_b)
  );

  // control sequencer and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      wp_q        <= '0;
      lp_q        <= ranrot_pkg::PtrW'(ranrot_pkg::LagStart);
      cnt_q       <= '0;
      seed_q      <= '0;
      out_valid_q <= 1'b0;
      out_word_q  <= '0;
    end else begin
      if (out_valid_q && rnd_o.ready) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        StIdle: begin
          if (cmd_acc) begin
            if (cmd_i.opcode == ranrot_pkg::OpDraw) begin
              state_q <= StCalc;
            end else begin
              seed_q  <= (cmd_i.seed_value != '0) ? cmd_i.seed_value : fallback_q;
              cnt_q   <= '0;
              state_q <= StSeed;
            end
          end
        end
        StCalc: begin
          if (out_free) begin
            out_word_q  <= word_d;
            out_valid_q <= 1'b1;
            wp_q        <= (wp_q == '0) ? ranrot_pkg::PtrW'(ranrot_pkg::RingLast) : wp_q - 1'b1;
            lp_q        <= (lp_q == '0) ? ranrot_pkg::PtrW'(ranrot_pkg::RingLast) : lp_q - 1'b1;
            state_q     <= StIdle;
          end
        end
        StSeed: begin
          seed_q <= seed_d;
          if (cnt_q == ranrot_pkg::PtrW'(ranrot_pkg::RingLast)) begin
            wp_q    <= '0;
            lp_q    <= ranrot_pkg::PtrW'(ranrot_pkg::LagStart);
            state_q <= StIdle;
          end else begin
            cnt_q <= cnt_q + 1'b1;
          end
        end
        default: begin
          state_q <= StIdle;
        end
      endcase
    end
  end

  // pointer distance helpers for the checks
  assign wp_ext = {1'b0, wp_q};
  assign lp_ext = {1'b0, lp_q};

  `RANROT_ASSERT_NR(a_ptr_range, clk_i, (wp_q <= ranrot_pkg::PtrW'(ranrot_pkg::RingLast)) && (lp_q <= ranrot_pkg::PtrW'(ranrot_pkg::RingLast)), "ring pointer out of range")
  `RANROT_ASSERT(a_ptr_gap, clk_i, rst_ni, (lp_ext == wp_ext + (ranrot_pkg::PtrW+1)'(ranrot_pkg::LagStart)) || (lp_ext + (ranrot_pkg::PtrW+1)'(ranrot_pkg::RingDepth - ranrot_pkg::LagStart) == wp_ext), "pointers lost their lag")
  `RANROT_ASSERT(a_seed_end, clk_i, rst_ni, (state_q == StSeed) && (cnt_q == ranrot_pkg::PtrW'(ranrot_pkg::RingLast)) |=> (wp_q == '0) && (state_q == StIdle), "reseed did not restore pointers")
  `RANROT_ASSERT(a_no_rw_overlap, clk_i, rst_ni, !(ring_req.wr_en && ring_req.rd_en), "ring read and write in one cycle")
  `RANROT_ASSERT(a_draw_calc, clk_i, rst_ni, cmd_acc && (cmd_i.opcode == ranrot_pkg::OpDraw) |=> (state_q == StCalc), "draw item did not reach compute")

endmodule

[tb/sv/testbench.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Checks the ranrot generator: reseed and draw items go in on cmd_i, every
// random word on rnd_o is compared with a model of the 17-word lagged ring
// kept here, while the fallback seed is moved through several values over APB
// ----------------------------------------------------------------------------
module testbench;

  typedef enum logic [1:0] {IdleNone, IdleSender, IdleReceiver, IdleBoth} idle_mode_e;

  // one row of the directed table; typed rows carry their expected word
  typedef struct packed {
    logic                         opcode;
    logic [ranrot_pkg::WordW-1:0] seed;
    logic                         typed;
    logic [ranrot_pkg::WordW-1:0] word;
  } stim_row_t;

  // one random phase: fallback seed setting and handshake behavior
  typedef struct packed {
    logic [ranrot_pkg::WordW-1:0] fallback;
    logic                         rand_fallback;
    idle_mode_e                   mode;
    logic                         long_hold;
  } phase_t;

  localparam logic Draw   = ranrot_pkg::OpDraw;
  localparam logic Reseed = ranrot_pkg::OpReseed;
  localparam logic [ranrot_pkg::ApbAddrW-1:0] FallbackSeedAddr =
    ranrot_pkg::ApbAddrW'(4 * int'(ranrot_pkg::RegFallbackSeed));
  localparam int DirectedRows   = 24;
  localparam int Phases         = 5;
  localparam int ItemsPerPhase  = 285;
  localparam int LongHoldCycles = 300;
  localparam int SettleCycles   = 24;

  localparam stim_row_t DirectedTable [DirectedRows] = '{
    // draws on the all-zero ring right after reset
    '{Draw,   32'h0000_0000, 1'b1, 32'h0000_0000},
    '{Draw,   32'hFFFF_FFFF, 1'b1, 32'h0000_0000},
    // zero seed takes the fallback seed at its reset value
    '{Reseed, 32'h0000_0000, 1'b0, 32'h0},
    '{Draw,   32'h0000_0000, 1'b0, 32'h0},
    '{Draw,   32'h0000_0000, 1'b0, 32'h0},
    '{Reseed, 32'hFFFF_FFFF, 1'b0, 32'h0},
    '{Draw,   32'hFFFF_FFFF, 1'b0, 32'h0},
    '{Reseed, 32'h0000_0001, 1'b0, 32'h0},
    '{Draw,   32'h5A5A_A5A5, 1'b0, 32'h0},
    '{Reseed, 32'h8000_0000, 1'b0, 32'h0},
    '{Draw,   32'h0000_0000, 1'b0, 32'h0},
    '{Reseed, 32'h7FFF_FFFF, 1'b0, 32'h0},
    // run both pointers past their wrap
    '{Draw,   32'h0000_0000, 1'b0, 32'h0},
    '{Draw,   32'h0000_0000, 1'b0, 32'h0},
    '{Draw,   32'h0000_0000, 1'b0, 32'h0},
    '{Draw,   32'h0000_0000, 1'b0, 32'h0},
    '{Draw,   32'h0000_0000, 1'b0, 32'h0},
    '{Draw,   32'h0000_0000, 1'b0, 32'h0},
    '{Draw,   32'h0000_0000, 1'b0, 32'h0},
    '{Draw,   32'h0000_0000, 1'b0, 32'h0},
    '{Draw,   32'h0000_0000, 1'b0, 32'h0},
    '{Draw,   32'h0000_0000, 1'b0, 32'h0},
    '{Draw,   32'h0000_0000, 1'b0, 32'h0},
    '{Draw,   32'h0000_0000, 1'b0, 32'h0}
  };

  localparam phase_t PhaseTable [Phases] = '{
    '{32'h0000_0000, 1'b0, IdleNone,     1'b1},
    '{32'hFFFF_FFFF, 1'b0, IdleSender,   1'b0},
    '{32'h0000_0000, 1'b1, IdleReceiver, 1'b0},
    '{32'h0000_0000, 1'b1, IdleBoth,     1'b0},
    '{32'h0000_0001, 1'b0, IdleNone,     1'b0}
  };

  logic                            clk_i;
  logic                            rst_ni;
  logic                            psel;
  logic                            penable;
  logic                            pwrite;
  logic [ranrot_pkg::ApbAddrW-1:0] paddr;
  logic [ranrot_pkg::ApbDataW-1:0] pwdata;
  logic [ranrot_pkg::ApbDataW-1:0] prdata;
  logic                            pready;

  ranrot_in_if  cmd_if ();
  ranrot_out_if rnd_if ();

  ranrot_random_generator dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cmd_i   (cmd_if),
    .rnd_o   (rnd_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // generator model state
  logic [ranrot_pkg::WordW-1:0] ring_model [ranrot_pkg::RingDepth];
  logic [ranrot_pkg::PtrW-1:0]  write_ptr_model;
  logic [ranrot_pkg::PtrW-1:0]  lag_ptr_model;
  logic [ranrot_pkg::WordW-1:0] fallback_model;

  logic [ranrot_pkg::WordW-1:0] pending_words [$];
  idle_mode_e                   idle_mode;
  bit                           hold_request;
  int                           mismatch_count;
  int                           draws_sent;
  int                           reseeds_sent;
  int                           zero_reseeds;
  int                           words_checked;
  int                           config_writes;

  // 100 MHz clock
  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  function automatic logic [ranrot_pkg::WordW-1:0] rotate_left(
      input logic [ranrot_pkg::WordW-1:0] v, input int amount);
    logic [2*ranrot_pkg::WordW-1:0] doubled;
    doubled = {v, v} << amount;
    return doubled[2*ranrot_pkg::WordW-1:ranrot_pkg::WordW];
  endfunction

  task automatic report_mismatch(input string what, input logic [ranrot_pkg::WordW-1:0] got,
                                 input logic [ranrot_pkg::WordW-1:0] want);
    $display("mismatch at %0t: %s got %08h expected %08h", $time, what, got, want);
    mismatch_count++;
  endtask

  // one APB transfer, setup then access, completing when pready is high
  task automatic apb_access(input logic is_write, input logic [ranrot_pkg::ApbDataW-1:0] wdata,
                            output logic [ranrot_pkg::ApbDataW-1:0] rdata);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= is_write;
    paddr   <= FallbackSeedAddr;
    pwdata  <= wdata;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    rdata = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // offer one item, wait for acceptance, then step the generator model
  task automatic offer_item(input logic op, input logic [ranrot_pkg::WordW-1:0] seed,
                            input logic typed, input logic [ranrot_pkg::WordW-1:0] typed_word);
    logic [ranrot_pkg::WordW-1:0] s;
    logic [ranrot_pkg::WordW-1:0] word;
    // random gaps before the item
    while ((idle_mode == IdleSender && $urandom_range(0, 99) < 75) ||
           (idle_mode == IdleBoth && $urandom_range(0, 99) < 19)) begin
      cmd_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    cmd_if.valid      <= 1'b1;
    cmd_if.opcode     <= op;
    cmd_if.seed_value <= seed;
    do @(posedge clk_i); while (!cmd_if.ready);
    if (op == Reseed) begin
      // refill the ring from the lcg chain
      s = (seed == '0) ? fallback_model : seed;
      for (int i = 0; i < ranrot_pkg::RingDepth; i++) begin
        s = s * ranrot_pkg::LcgMult + 1;
        ring_model[i] = s;
      end
      write_ptr_model = '0;
      lag_ptr_model   = ranrot_pkg::PtrW'(ranrot_pkg::LagStart);
      reseeds_sent++;
      if (seed == '0) zero_reseeds++;
    end else begin
      // rotate-add, write back, both pointers step down with wrap
      word = rotate_left(ring_model[lag_ptr_model], ranrot_pkg::RotLag) +
             rotate_left(ring_model[write_ptr_model], ranrot_pkg::RotWrite);
      ring_model[write_ptr_model] = word;
      write_ptr_model = (write_ptr_model == '0) ? ranrot_pkg::PtrW'(ranrot_pkg::RingLast)
                                                : write_ptr_model - 1'b1;
      lag_ptr_model   = (lag_ptr_model == '0) ? ranrot_pkg::PtrW'(ranrot_pkg::RingLast)
                                              : lag_ptr_model - 1'b1;
      pending_words.push_back(typed ? typed_word : word);
      draws_sent++;
    end
  endtask

  // result side: check each word, then pick ready for the next cycle
  initial begin
    int hold_left;
    logic [ranrot_pkg::WordW-1:0] want;
    hold_left = 0;
    rnd_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (rnd_if.valid && rnd_if.ready) begin
        if (pending_words.size() == 0) begin
          report_mismatch("unexpected random_word", rnd_if.random_word, '0);
        end else begin
          want = pending_words.pop_front();
          if (rnd_if.random_word !== want) begin
            report_mismatch("random_word", rnd_if.random_word, want);
          end
          words_checked++;
        end
      end
      if (hold_request) begin
        hold_request = 1'b0;
        hold_left = LongHoldCycles;
      end
      if (hold_left > 0) begin
        hold_left--;
        rnd_if.ready <= 1'b0;
      end else if (idle_mode == IdleReceiver) begin
        rnd_if.ready <= ($urandom_range(0, 99) >= 75);
      end else if (idle_mode == IdleBoth) begin
        rnd_if.ready <= ($urandom_range(0, 99) >= 19);
      end else begin
        rnd_if.ready <= 1'b1;
      end
    end
  end

  // watchdog
  initial begin
    #5_000_000;
    $display("testbench: FAIL");
    $finish;
  end

  // stimulus
  initial begin
    logic [ranrot_pkg::ApbDataW-1:0] rdata;
    logic [ranrot_pkg::WordW-1:0]    setting;
    logic                            op;
    logic [ranrot_pkg::WordW-1:0]    seed;
    rst_ni            <= 1'b0;
    cmd_if.valid      <= 1'b0;
    cmd_if.opcode     <= Draw;
    cmd_if.seed_value <= '0;
    psel              <= 1'b0;
    penable           <= 1'b0;
    pwrite            <= 1'b0;
    paddr             <= '0;
    pwdata            <= '0;
    idle_mode      = IdleNone;
    hold_request   = 1'b0;
    mismatch_count = 0;
    draws_sent     = 0;
    reseeds_sent   = 0;
    zero_reseeds   = 0;
    words_checked  = 0;
    config_writes  = 0;
    for (int i = 0; i < ranrot_pkg::RingDepth; i++) ring_model[i] = '0;
    write_ptr_model = '0;
    lag_ptr_model   = ranrot_pkg::PtrW'(ranrot_pkg::LagStart);
    fallback_model  = 32'h1;

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed part
    for (int i = 0; i < DirectedRows; i++) begin
      offer_item(DirectedTable[i].opcode, DirectedTable[i].seed,
                 DirectedTable[i].typed, DirectedTable[i].word);
    end
    cmd_if.valid <= 1'b0;

    // random phases, each with its own fallback seed and idle pattern
    for (int p = 0; p < Phases; p++) begin
      while (pending_words.size() != 0) @(posedge clk_i);
      repeat (SettleCycles) @(posedge clk_i);
      setting = PhaseTable[p].rand_fallback ? $urandom() : PhaseTable[p].fallback;
      apb_access(1'b1, setting, rdata);
      fallback_model = setting;
      config_writes++;
      // the bus goes idle between the write and the readback
      @(posedge clk_i);
      apb_access(1'b0, '0, rdata);
      if (rdata !== setting) report_mismatch("fallback_seed readback", rdata, setting);
      idle_mode = PhaseTable[p].mode;
      if (PhaseTable[p].long_hold) hold_request = 1'b1;
      for (int n = 0; n < ItemsPerPhase; n++) begin
        if ($urandom_range(0, 9) == 0) begin
          op = Reseed;
          case ($urandom_range(0, 3))
            0: seed = '0;
            1: seed = '1;
            default: seed = $urandom();
          endcase
        end else begin
          op = Draw;
          seed = $urandom();
        end
        offer_item(op, seed, 1'b0, '0);
      end
      cmd_if.valid <= 1'b0;
    end

    // drain
    idle_mode = IdleNone;
    while (pending_words.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);

    $display("covered %0d draws and %0d reseeds (%0d with a zero seed), %0d words checked",
             draws_sent, reseeds_sent, zero_reseeds, words_checked);
    $display("over %0d fallback seed settings, four idle patterns and one long output stall",
             config_writes);
    if (mismatch_count == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

endmodule
